FILE: hw/rtl/assert_macros.svh
// Assertion macros used by tms_dp, the datapath of the Turing machine block.
// No dependencies; the bodies drop out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: condition does not hold");
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication does not hold");
`define ASSERT_IMPLIES_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication does not hold");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_IMPLIES_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/tms_pkg.sv
// Shared types and constants of the Turing machine block.
// No dependencies; used by tms_ctrl, tms_dp and turing_machine_step.
package tms_pkg;

  localparam int TMS_RULE_DEPTH = 128;
  localparam int TMS_TAPE_DEPTH = 1024;

  localparam int IN_DATA_W  = 64;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int HEAD_W     = 11;  // head can pass 1023 when the store is deep
  localparam int LEN_W      = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_RULE_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_HEAD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAPE_LENGTH = 2'd2;

  localparam logic [1:0] HALT_RUNNING    = 2'd0;
  localparam logic [1:0] HALT_NO_RULE    = 2'd1;
  localparam logic [1:0] HALT_LEFT_END   = 2'd2;
  localparam logic [1:0] HALT_RIGHT_END  = 2'd3;

  typedef enum logic [2:0] {
    OP_STEP      = 3'd0,
    OP_LOAD_RULE = 3'd1,
    OP_LOAD_CELL = 3'd2,
    OP_READ_CELL = 3'd3,
    OP_RESTART   = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_APPLY,
    ST_READ,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [7:0] match_state;
    logic [7:0] match_symbol;
    logic [7:0] write_symbol;
    logic       move_right;
    logic [7:0] next_state;
  } rule_t;

  typedef struct packed {
    logic item_latch;
    logic rule_wr;
    logic tape_wr_cell;
    logic tape_rd_cell;
    logic sym_capture;
    logic restart;
    logic halt_outside;
    logic tape_rd_head;
    logic scan_run;
    logic halt_nomatch;
    logic apply;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic halted;
    logic head_outside;
    logic hit;
    logic miss;
    logic out_free;
  } status_t;

endpackage

FILE: hw/rtl/tms_ctrl.sv
// Sequencer of the Turing machine block: one item at a time from accept to result.
// Depends on tms_pkg; drives the command struct of tms_dp.
module tms_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tms_pkg::status_t  status,
  output tms_pkg::cmd_t     cmd
);

  tms_pkg::state_t state;
  tms_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tms_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tms_pkg::ST_IDLE: begin
        if (in_valid) state_next = tms_pkg::ST_EXEC;
      end
      tms_pkg::ST_EXEC: begin
        unique case (status.op)
          tms_pkg::OP_STEP: begin
            if (status.halted || status.head_outside) begin
              state_next = tms_pkg::ST_RESP;
            end else begin
              state_next = tms_pkg::ST_SCAN;
            end
          end
          tms_pkg::OP_READ_CELL: state_next = tms_pkg::ST_READ;
          default:               state_next = tms_pkg::ST_RESP;
        endcase
      end
      tms_pkg::ST_SCAN: begin
        if (status.hit) begin
          state_next = tms_pkg::ST_APPLY;
        end else if (status.miss) begin
          state_next = tms_pkg::ST_RESP;
        end
      end
      tms_pkg::ST_APPLY: state_next = tms_pkg::ST_RESP;
      tms_pkg::ST_READ:  state_next = tms_pkg::ST_RESP;
      tms_pkg::ST_RESP: begin
        if (status.out_free) state_next = tms_pkg::ST_IDLE;
      end
      default: state_next = tms_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      tms_pkg::ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.item_latch = in_valid;
      end
      tms_pkg::ST_EXEC: begin
        unique case (status.op)
          tms_pkg::OP_STEP: begin
            if (!status.halted) begin
              cmd.halt_outside = status.head_outside;
              cmd.tape_rd_head = !status.head_outside;
            end
          end
          tms_pkg::OP_LOAD_RULE: cmd.rule_wr      = 1'b1;
          tms_pkg::OP_LOAD_CELL: cmd.tape_wr_cell = 1'b1;
          tms_pkg::OP_READ_CELL: cmd.tape_rd_cell = 1'b1;
          tms_pkg::OP_RESTART:   cmd.restart      = 1'b1;
          default: ;
        endcase
      end
      tms_pkg::ST_SCAN: begin
        cmd.scan_run     = 1'b1;
        cmd.halt_nomatch = status.miss && !status.hit;
      end
      tms_pkg::ST_APPLY: cmd.apply       = 1'b1;
      tms_pkg::ST_READ:  cmd.sym_capture = 1'b1;
      tms_pkg::ST_RESP:  cmd.out_load    = status.out_free;
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/tms_dp.sv
// Datapath of the Turing machine block: item and config registers, rule and
// tape memories, rule scan, machine state and result register. Depends on tms_pkg.
`include "assert_macros.svh"
module tms_dp #(
  parameter int RULE_DEPTH = tms_pkg::TMS_RULE_DEPTH,
  parameter int TAPE_DEPTH = tms_pkg::TMS_TAPE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [tms_pkg::IN_DATA_W-1:0]   in_data,
  input  logic [tms_pkg::IN_USER_W-1:0]   in_user,
  input  logic                            cfg_we,
  input  logic [tms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tms_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  tms_pkg::cmd_t                   cmd,
  output tms_pkg::status_t                status,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [tms_pkg::OUT_DATA_W-1:0]  out_data
);

  localparam int RA = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
  localparam int TA = $clog2(TAPE_DEPTH);
  localparam int CW = $clog2(RULE_DEPTH + 1);

  // latched item
  tms_pkg::op_t   it_op;
  logic [6:0]     it_slot;
  tms_pkg::rule_t it_rule;
  logic [9:0]     it_pos;
  logic [7:0]     it_sym;

  // configuration
  logic [7:0]                  rule_count;
  logic [9:0]                  start_head;
  logic [tms_pkg::LEN_W-1:0]   tape_length;

  // machine
  logic [tms_pkg::HEAD_W-1:0]  head;
  logic [7:0]                  cur_state;
  logic                        halt_flag;
  logic [1:0]                  halt_cause;

  tms_pkg::rule_t rule_mem [RULE_DEPTH];
  tms_pkg::rule_t rule_q;
  logic [7:0]     tape_mem [TAPE_DEPTH];
  logic [7:0]     tape_q;

  logic [CW-1:0]  scan_idx;
  logic           cmp_valid;
  logic [7:0]     sym_res;

  logic [tms_pkg::LEN_W-1:0]   len;
  logic [7:0]                  n_rules;
  logic                        slot_ok;
  logic                        pos_ok;
  logic                        hit;
  logic                        scan_end;
  logic                        at_right;
  logic [TA-1:0]               tape_addr;
  logic                        tape_we;
  logic                        tape_re;
  logic [7:0]                  tape_wd;

  always_comb begin
    len = tape_length;
    if (tape_length == '0) len = tms_pkg::LEN_W'(1);
    if (32'(tape_length) > TAPE_DEPTH) len = tms_pkg::LEN_W'(TAPE_DEPTH);
  end

  assign n_rules  = (32'(rule_count) > RULE_DEPTH) ? 8'(RULE_DEPTH) : rule_count;
  assign slot_ok  = 32'(it_slot) < RULE_DEPTH;
  assign pos_ok   = 32'(it_pos) < TAPE_DEPTH;
  assign hit      = cmp_valid && (rule_q.match_state == cur_state)
                    && (rule_q.match_symbol == tape_q);
  assign scan_end = scan_idx >= CW'(n_rules);
  assign at_right = ({1'b0, head} + (tms_pkg::HEAD_W + 1)'(1)) >= {1'b0, len};

  assign status.op           = it_op;
  assign status.halted       = halt_flag;
  assign status.head_outside = head >= len;
  assign status.hit          = hit;
  assign status.miss         = scan_end && !hit;
  assign status.out_free     = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.item_latch) begin
      it_op                <= tms_pkg::op_t'(in_user);
      it_slot              <= in_data[6:0];
      it_rule.match_state  <= in_data[14:7];
      it_rule.match_symbol <= in_data[22:15];
      it_rule.write_symbol <= in_data[30:23];
      it_rule.move_right   <= in_data[31];
      it_rule.next_state   <= in_data[39:32];
      it_pos               <= in_data[49:40];
      it_sym               <= in_data[57:50];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rule_count  <= '0;
      start_head  <= '0;
      tape_length <= tms_pkg::LEN_W'(1024);
    end else if (cfg_we) begin
      unique case (cfg_index)
        tms_pkg::CFG_RULE_COUNT:  rule_count  <= cfg_data[7:0];
        tms_pkg::CFG_START_HEAD:  start_head  <= cfg_data[9:0];
        tms_pkg::CFG_TAPE_LENGTH: tape_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // rule memory: written by load rule, read one entry a cycle during the scan
  always_ff @(posedge clk) begin
    if (cmd.rule_wr && slot_ok) rule_mem[RA'(it_slot)] <= it_rule;
    if (cmd.scan_run && !hit && !scan_end) rule_q <= rule_mem[scan_idx[RA-1:0]];
  end

  assign tape_addr = (cmd.apply || cmd.tape_rd_head) ? TA'(head) : TA'(it_pos);
  assign tape_we   = (cmd.tape_wr_cell && pos_ok) || cmd.apply;
  assign tape_re   = cmd.tape_rd_head || (cmd.tape_rd_cell && pos_ok);
  assign tape_wd   = cmd.apply ? rule_q.write_symbol : it_sym;

  always_ff @(posedge clk) begin
    if (tape_we) tape_mem[tape_addr] <= tape_wd;
    if (tape_re) tape_q <= tape_mem[tape_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx  <= '0;
      cmp_valid <= 1'b0;
    end else if (cmd.tape_rd_head) begin
      scan_idx  <= '0;
      cmp_valid <= 1'b0;
    end else if (cmd.scan_run && !hit) begin
      // advance only while candidates remain; the last compare drains with no new read
      cmp_valid <= !scan_end;
      if (!scan_end) scan_idx <= scan_idx + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      cur_state  <= '0;
      halt_flag  <= 1'b0;
      halt_cause <= tms_pkg::HALT_RUNNING;
    end else if (cmd.restart) begin
      head       <= tms_pkg::HEAD_W'(start_head);
      cur_state  <= '0;
      halt_flag  <= 1'b0;
      halt_cause <= tms_pkg::HALT_RUNNING;
    end else if (cmd.halt_outside) begin
      halt_flag  <= 1'b1;
      halt_cause <= tms_pkg::HALT_RIGHT_END;
    end else if (cmd.halt_nomatch) begin
      halt_flag  <= 1'b1;
      halt_cause <= tms_pkg::HALT_NO_RULE;
    end else if (cmd.apply) begin
      cur_state <= rule_q.next_state;
      if (rule_q.move_right) begin
        if (at_right) begin
          halt_flag  <= 1'b1;
          halt_cause <= tms_pkg::HALT_RIGHT_END;
        end else begin
          head <= head + tms_pkg::HEAD_W'(1);
        end
      end else begin
        if (head == '0) begin
          halt_flag  <= 1'b1;
          halt_cause <= tms_pkg::HALT_LEFT_END;
        end else begin
          head <= head - tms_pkg::HEAD_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.item_latch) begin
      sym_res <= '0;
    end else if (cmd.sym_capture && pos_ok) begin
      sym_res <= tape_q;
    end else if (cmd.apply) begin
      sym_res <= rule_q.write_symbol;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {3'b000, sym_res, cur_state, head[9:0], halt_flag,
                   halt_flag ? halt_cause : tms_pkg::HALT_RUNNING};
    end
  end

  `ASSERT_ALWAYS(a_cause_only_halted, clk, rst, halt_flag || (halt_cause == tms_pkg::HALT_RUNNING))
  `ASSERT_IMPLIES(a_apply_on_hit, clk, rst, cmd.apply, hit)
  `ASSERT_ALWAYS(a_one_mem_write, clk, rst, $onehot0({cmd.rule_wr, cmd.tape_wr_cell, cmd.apply}))
  `ASSERT_IMPLIES_NEXT(a_scan_bounded, clk, rst, cmd.scan_run, scan_idx <= CW'(n_rules))

endmodule

FILE: hw/rtl/turing_machine_step.sv
// Single-tape Turing machine: one command in, one result out, one command at a time.
// Step: the rule memory, up to the rule count in use, is read one entry per cycle in order
// until the first match. A new command is taken while a finished result waits.
// Synchronous reset clears state, head, halt and the output valid; config returns to its
// defaults. Rule and tape memories are not cleared and hold garbage until loaded.
module turing_machine_step #(
  parameter int RULE_DEPTH = tms_pkg::TMS_RULE_DEPTH,
  parameter int TAPE_DEPTH = tms_pkg::TMS_TAPE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // rule_slot[6:0], match_state[14:7], match_symbol[22:15], write_symbol[30:23],
  // move_right[31], next_state[39:32], cell_position[49:40], cell_symbol[57:50]
  input  logic [tms_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // command[2:0]
  input  logic [tms_pkg::IN_USER_W-1:0]   s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // status[1:0], halted[2], head_position[12:3], machine_state[20:13], symbol_out[28:21]
  output logic [tms_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                            cfg_we,
  input  logic [tms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tms_pkg::CFG_DATA_W-1:0]  cfg_data
);

  tms_pkg::cmd_t    cmd;
  tms_pkg::status_t status;

  tms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tms_dp #(
    .RULE_DEPTH (RULE_DEPTH),
    .TAPE_DEPTH (TAPE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata)
  );

endmodule

FILE: verif/tb_turing_machine_step.sv
`timescale 1ns / 1ps
// Self-checking testbench for turing_machine_step: stream driver and monitor,
// an in-bench machine predictor and register writes between phases.
// Depends on tms_pkg and the turing_machine_step RTL only.
module tb_turing_machine_step;
  import tms_pkg::*;

  localparam int PLAN = 0;  // copy advanced as items are queued
  localparam int LIVE = 1;  // copy advanced as transactions are accepted
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int ITEM_TARGET = 1450;

  typedef struct {
    logic [2:0] cmd;
    logic [6:0] slot;
    logic [7:0] mstate;
    logic [7:0] msym;
    logic [7:0] wsym;
    logic       mright;
    logic [7:0] nstate;
    logic [9:0] pos;
    logic [7:0] csym;
  } tm_item_t;

  typedef struct {
    logic [1:0] code;
    logic       halted;
    logic [9:0] head;
    logic [7:0] mstate;
    logic [7:0] symbol;
  } tm_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  turing_machine_step DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Register shadows, shared by both machine copies (only written while idle)
  int unsigned rule_count_reg = 0;
  int unsigned start_head_reg = 0;
  int unsigned tape_len_reg = 1024;

  bit [7:0]    tape_img [2][TMS_TAPE_DEPTH];
  rule_t       rule_img [2][TMS_RULE_DEPTH];
  int unsigned head_img [2];
  logic [7:0]  state_img [2];
  bit          halt_img [2];
  logic [1:0]  cause_img [2];
  bit          cell_loaded [TMS_TAPE_DEPTH];

  tm_item_t   pending_items [$];
  tm_result_t expected_results [$];
  tm_item_t   cur_item;
  int         items_made = 0;
  int         items_taken = 0;
  int         mismatches = 0;
  int         hold_left = 0;
  int         holds_given = 0;

  function automatic int unsigned tape_in_use();
    int unsigned n;
    n = (tape_len_reg == 0) ? 1 : tape_len_reg;
    if (n > TMS_TAPE_DEPTH) n = TMS_TAPE_DEPTH;
    return n;
  endfunction

  // Advance one machine copy by one command and return the result it reports
  function automatic tm_result_t machine_advance(input int c, input tm_item_t it);
    tm_result_t  r;
    int unsigned len;
    int unsigned n;
    logic [7:0]  sym;
    bit          fired;
    len = tape_in_use();
    n = (rule_count_reg > TMS_RULE_DEPTH) ? TMS_RULE_DEPTH : rule_count_reg;
    r.symbol = 8'h00;
    case (it.cmd)
      OP_STEP: begin
        if (!halt_img[c]) begin
          if (head_img[c] >= len) begin
            halt_img[c] = 1'b1;
            cause_img[c] = HALT_RIGHT_END;
          end else begin
            sym = tape_img[c][head_img[c]];
            fired = 1'b0;
            for (int i = 0; i < n; i++) begin
              if (!fired && rule_img[c][i].match_state == state_img[c] &&
                  rule_img[c][i].match_symbol == sym) begin
                fired = 1'b1;
                tape_img[c][head_img[c]] = rule_img[c][i].write_symbol;
                state_img[c] = rule_img[c][i].next_state;
                r.symbol = rule_img[c][i].write_symbol;
                if (rule_img[c][i].move_right) begin
                  if (head_img[c] + 1 >= len) begin
                    halt_img[c] = 1'b1;
                    cause_img[c] = HALT_RIGHT_END;
                  end else begin
                    head_img[c]++;
                  end
                end else if (head_img[c] == 0) begin
                  halt_img[c] = 1'b1;
                  cause_img[c] = HALT_LEFT_END;
                end else begin
                  head_img[c]--;
                end
              end
            end
            if (!fired) begin
              halt_img[c] = 1'b1;
              cause_img[c] = HALT_NO_RULE;
            end
          end
        end
      end
      OP_LOAD_RULE: begin
        rule_img[c][it.slot].match_state = it.mstate;
        rule_img[c][it.slot].match_symbol = it.msym;
        rule_img[c][it.slot].write_symbol = it.wsym;
        rule_img[c][it.slot].move_right = it.mright;
        rule_img[c][it.slot].next_state = it.nstate;
      end
      OP_LOAD_CELL: tape_img[c][it.pos] = it.csym;
      OP_READ_CELL: r.symbol = tape_img[c][it.pos];
      OP_RESTART: begin
        state_img[c] = 8'h00;
        head_img[c] = start_head_reg;
        halt_img[c] = 1'b0;
        cause_img[c] = HALT_RUNNING;
      end
      default: ;
    endcase
    r.code = halt_img[c] ? cause_img[c] : HALT_RUNNING;
    r.halted = halt_img[c];
    r.head = head_img[c][9:0];
    r.mstate = state_img[c];
    return r;
  endfunction

  // Idling is suspended for a stretch of the run
  function automatic bit jitter_on();
    return !(items_taken >= 600 && items_taken < 800);
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  // Random filler in every field, then the chosen command
  function automatic tm_item_t fresh_item(input logic [2:0] code);
    tm_item_t it;
    it.cmd = code;
    it.slot = 7'($urandom);
    it.mstate = 8'($urandom);
    it.msym = 8'($urandom);
    it.wsym = 8'($urandom);
    it.mright = 1'($urandom);
    it.nstate = 8'($urandom);
    it.pos = 10'($urandom);
    it.csym = 8'($urandom);
    return it;
  endfunction

  task automatic queue_item(input tm_item_t it);
    tm_result_t unused;
    bit         ignored;
    ignored = (it.cmd > OP_RESTART) || (it.cmd == OP_STEP && halt_img[PLAN]);
    unused = machine_advance(PLAN, it);
    if (it.cmd == OP_LOAD_CELL) cell_loaded[it.pos] = 1'b1;
    if (!ignored) items_made++;
    pending_items.push_back(it);
  endtask

  task automatic do_cmd(input logic [2:0] code);
    queue_item(fresh_item(code));
  endtask

  task automatic load_rule(input logic [6:0] slot, input logic [7:0] ms, input logic [7:0] msym,
                           input logic [7:0] ws, input logic mr, input logic [7:0] ns);
    tm_item_t it;
    it = fresh_item(OP_LOAD_RULE);
    it.slot = slot;
    it.mstate = ms;
    it.msym = msym;
    it.wsym = ws;
    it.mright = mr;
    it.nstate = ns;
    queue_item(it);
  endtask

  task automatic load_cell(input logic [9:0] pos, input logic [7:0] sym);
    tm_item_t it;
    it = fresh_item(OP_LOAD_CELL);
    it.pos = pos;
    it.csym = sym;
    queue_item(it);
  endtask

  task automatic do_read(input logic [9:0] pos);
    tm_item_t it;
    if (!cell_loaded[pos]) load_cell(pos, 8'($urandom));
    it = fresh_item(OP_READ_CELL);
    it.pos = pos;
    queue_item(it);
  endtask

  // Fill the cell under the head first so a step never reads an unloaded cell
  task automatic do_step(input logic [7:0] fill);
    if (!halt_img[PLAN] && head_img[PLAN] < tape_in_use() && !cell_loaded[head_img[PLAN]])
      load_cell(head_img[PLAN][9:0], fill);
    do_cmd(OP_STEP);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_items.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_RULE_COUNT: rule_count_reg = val & 32'hFF;
      CFG_START_HEAD: start_head_reg = val & 32'h3FF;
      CFG_TAPE_LENGTH: tape_len_reg = val & 32'h7FF;
      default: ;
    endcase
  endtask

  // Driver: advance the live copy on each accepted transaction, then offer the next item
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(machine_advance(LIVE, cur_item));
        items_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_items.size() != 0 && !(jitter_on() && $urandom_range(99, 0) < 26)) begin
          cur_item = pending_items.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {6'd0, cur_item.csym, cur_item.pos, cur_item.nstate, cur_item.mright,
                           cur_item.wsym, cur_item.msym, cur_item.mstate, cur_item.slot};
          s_axis_tuser <= cur_item.cmd;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-offs so the block fills up and stalls its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_given < 2 && items_taken >= 300 + 700 * holds_given) begin
      hold_left <= 500;
      holds_given <= holds_given + 1;
    end
  end

  // Monitor: compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    tm_result_t            want;
    logic [OUT_DATA_W-1:0] got;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result 0x%0h with no command outstanding", got));
        end else begin
          want = expected_results.pop_front();
          check_field("status", 16'(got[1:0]), 16'(want.code));
          check_field("halted", 16'(got[2]), 16'(want.halted));
          check_field("head_position", 16'(got[12:3]), 16'(want.head));
          check_field("machine_state", 16'(got[20:13]), 16'(want.mstate));
          check_field("symbol_out", 16'(got[28:21]), 16'(want.symbol));
        end
      end
      m_axis_tready <= (hold_left == 0) && !(jitter_on() && $urandom_range(99, 0) < 26);
    end
  end

  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int unsigned rc;
    int unsigned len;
    int unsigned sh;
    int unsigned eff;
    int          pick;
    int          phase_no;
    int          nstates;
    int          nsyms;
    int          steps;
    logic [7:0]  state_ids [4];
    logic [7:0]  syms [3];

    for (int c = 0; c < 2; c++) begin
      head_img[c] = 0;
      state_img[c] = 8'h00;
      halt_img[c] = 1'b0;
      cause_img[c] = HALT_RUNNING;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, halted steps, spare codes, field extremes
    load_cell(10'd0, 8'h00);
    do_step(8'h00);
    do_step(8'h00);
    for (int c = int'(OP_SPARE_LO); c <= int'(OP_SPARE_HI); c++) do_cmd(c[2:0]);
    load_cell(10'h3FF, 8'hFF);
    do_read(10'h3FF);
    do_read(10'd0);
    load_rule(7'h7F, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF);
    load_rule(7'd0, 8'h00, 8'h00, 8'hFF, 1'b0, 8'hFF);
    load_rule(7'd1, 8'h00, 8'hFF, 8'h00, 1'b1, 8'h00);
    do_cmd(OP_RESTART);
    wait_drained();
    write_reg(CFG_RULE_COUNT, 2);
    do_step(8'h00);  // move left off cell 0
    do_step(8'h00);
    wait_drained();
    write_reg(CFG_START_HEAD, 1023);
    do_cmd(OP_RESTART);
    do_step(8'hFF);  // move right off the last cell
    wait_drained();
    write_reg(CFG_TAPE_LENGTH, 0);
    write_reg(CFG_START_HEAD, 5);
    do_cmd(OP_RESTART);
    do_step(8'h00);  // head beyond the tape in use
    wait_drained();
    write_reg(CFG_TAPE_LENGTH, 1024);
    write_reg(CFG_START_HEAD, 0);
    do_cmd(OP_RESTART);
    do_step(8'h00);
    do_read(10'd0);

    // Random phases: new settings and a new program, then mostly steps
    phase_no = 0;
    while (items_made < ITEM_TARGET) begin
      wait_drained();
      if (phase_no % 8 == 3) rc = (phase_no % 16 == 3) ? 128 : $urandom_range(255, 129);
      else if ($urandom_range(9, 0) == 0) rc = 0;
      else rc = $urandom_range(10, 1);
      pick = $urandom_range(9, 0);
      case (pick)
        0: len = 1024;
        1: len = $urandom_range(2047, 1025);
        2: len = $urandom_range(1, 0);
        default: len = $urandom_range(40, 3);
      endcase
      write_reg(CFG_RULE_COUNT, rc);
      write_reg(CFG_TAPE_LENGTH, len);
      pick = $urandom_range(9, 0);
      if (pick == 0) sh = 1023;
      else if (pick == 1) sh = $urandom_range(1023, 0);
      else sh = $urandom_range(tape_in_use() - 1, 0);
      write_reg(CFG_START_HEAD, sh);

      nstates = $urandom_range(4, 1);
      nsyms = $urandom_range(3, 2);
      state_ids[0] = 8'h00;
      for (int i = 1; i < 4; i++) state_ids[i] = 8'($urandom);
      for (int i = 0; i < 3; i++) syms[i] = 8'($urandom);
      eff = (rc > TMS_RULE_DEPTH) ? TMS_RULE_DEPTH : rc;
      for (int s = 0; s < eff; s++) begin
        // Deep tables: push the useful rules to the end so the scan runs long
        if (eff > 16 && s < eff - 12)
          load_rule(s[6:0], 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                    8'($urandom));
        else
          load_rule(s[6:0], state_ids[$urandom_range(nstates - 1, 0)],
                    syms[$urandom_range(nsyms - 1, 0)], syms[$urandom_range(nsyms - 1, 0)],
                    1'($urandom), state_ids[$urandom_range(nstates - 1, 0)]);
      end
      do_cmd(OP_RESTART);

      steps = (eff > 16) ? $urandom_range(25, 12) : $urandom_range(60, 25);
      repeat (steps) begin
        pick = $urandom_range(99, 0);
        if (halt_img[PLAN] && pick < 60) do_cmd(OP_RESTART);
        else if (pick < 75) do_step(syms[$urandom_range(nsyms - 1, 0)]);
        else if (pick < 83) do_cmd(OP_RESTART);
        else if (pick < 88)
          do_read(10'($urandom_range(1, 0) ? $urandom_range(1023, 0)
                                           : $urandom_range(tape_in_use() - 1, 0)));
        else if (pick < 92)
          load_cell(10'($urandom), $urandom_range(1, 0) ? 8'($urandom)
                                                        : syms[$urandom_range(nsyms - 1, 0)]);
        else if (pick < 96)
          load_rule(7'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                    8'($urandom));
        else do_cmd(3'($urandom_range(32'(OP_SPARE_HI), 32'(OP_SPARE_LO))));
      end
      phase_no++;
    end

    wait_drained();
    repeat (300) @(posedge clk);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

FILE: turing_machine_step.f
+incdir+hw/rtl
hw/rtl/tms_pkg.sv
hw/rtl/tms_ctrl.sv
hw/rtl/tms_dp.sv
hw/rtl/turing_machine_step.sv
verif/tb_turing_machine_step.sv
